// ----- design/nnsb_pkg.sv -----
package nnsb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] RegTexWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTexHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSrcX      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSrcY      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSrcWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSrcHeight = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDstWidth  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDstHeight = 3'd7;

  localparam logic OpWriteTexel = 1'b0;
  localparam logic OpEmitPixel  = 1'b1;

  localparam int unsigned TexelW     = 24;
  localparam int unsigned StoreDepth = 65536;
  localparam int unsigned StoreAddrW = 16;

  typedef struct packed {
    logic        opcode;
    logic [15:0] texel_index;
    logic [31:0] texel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] out_column;
    logic [9:0] out_row;
    logic       frame_last;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StDivide,
    StClamp,
    StAddr,
    StRead,
    StOut
  } state_e;

endpackage

// ----- design/nnsb_ram.sv -----
module nnsb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/nnsb_div.sv -----
module nnsb_div #(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic             running_q, running_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   shifted;
  logic             fits;

  always_comb begin
    shifted   = {rem_q, quo_q[NUM_W-1]};
    fits      = shifted >= {1'b0, den_q};
    running_d = running_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    den_d     = den_q;
    quo_d     = quo_q;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = CntW'(NUM_W);
      rem_d     = '0;
      den_d     = den_i;
      quo_d     = num_i;
    end else if (running_q) begin
      rem_d = fits ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = running_q;
  assign quot_o = quo_q;

endmodule

// ----- design/nearest_neighbor_scaling_blit.sv -----
// A texel write item is written while busy stays low, so writes can follow back to back.
// An emit item holds busy high through the 19-step bit-serial divisions of
// both axes, then clamp, address, memory read and output. The next item is accepted
// only after the output state, once busy has gone low again.
// The pixel is shown for exactly one cycle on out_valid_o; the receiver cannot stall.
// Reset clears the counters and loads the register defaults; the texture is undefined.
module nearest_neighbor_scaling_blit #(
  parameter int unsigned MAX_TEX_WIDTH   = 256,
  parameter int unsigned MAX_TEX_HEIGHT  = 256,
  parameter int unsigned MAX_DEST_WIDTH  = 1024,
  parameter int unsigned MAX_DEST_HEIGHT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  nnsb_pkg::in_item_t                in_i,
  input  logic                              cfg_we_i,
  input  logic [nnsb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [nnsb_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                              out_valid_o,
  output nnsb_pkg::out_item_t               out_o
);

  localparam int unsigned ColW  = 10;
  localparam int unsigned RowW  = 10;
  localparam int unsigned ColXW = (ColW > 11) ? ColW : 11;
  localparam int unsigned RowXW = (RowW > 11) ? RowW : 11;
  localparam int unsigned NumXW = ColW + 9;
  localparam int unsigned NumYW = RowW + 9;
  localparam int unsigned SumXW = NumXW + 1;
  localparam int unsigned SumYW = NumYW + 1;

  localparam logic [8:0]  TexWCap = (MAX_TEX_WIDTH > 511) ? 9'd511 : 9'(MAX_TEX_WIDTH);
  localparam logic [8:0]  TexHCap = (MAX_TEX_HEIGHT > 511) ? 9'd511 : 9'(MAX_TEX_HEIGHT);
  localparam logic [10:0] DstWCap = (MAX_DEST_WIDTH > 2047) ? 11'd2047
                                                            : 11'(MAX_DEST_WIDTH);
  localparam logic [10:0] DstHCap = (MAX_DEST_HEIGHT > 2047) ? 11'd2047
                                                             : 11'(MAX_DEST_HEIGHT);

  nnsb_pkg::state_e state_q, state_d;

  logic [8:0]  tex_w_q, tex_h_q, src_w_q, src_h_q;
  logic [7:0]  src_x_q, src_y_q;
  logic [10:0] dst_w_q, dst_h_q;

  logic [8:0]  tw_sat, th_sat, sw_sat, sh_sat;
  logic [10:0] dw_sat, dh_sat;

  logic [ColW-1:0] col_q, col_d, col_out_q;
  logic [RowW-1:0] row_q, row_d, row_out_q;
  logic            last_q;

  logic accept, emit, texel_write;

  logic             div_x_busy, div_y_busy;
  logic [NumXW-1:0] quot_x;
  logic [NumYW-1:0] quot_y;
  logic [SumXW-1:0] sum_x;
  logic [SumYW-1:0] sum_y;
  logic [8:0]       tx_d, ty_d, tx_q, ty_q;

  logic [nnsb_pkg::StoreAddrW-1:0] addr_q, addr_d, ram_addr;
  logic [nnsb_pkg::TexelW-1:0]     ram_rdata;

  assign accept      = start && !busy;
  assign emit        = accept && (in_i.opcode == nnsb_pkg::OpEmitPixel);
  assign texel_write = accept && (in_i.opcode == nnsb_pkg::OpWriteTexel);

  always_comb begin
    tw_sat = (tex_w_q == '0) ? 9'd1 : ((tex_w_q > TexWCap) ? TexWCap : tex_w_q);
    th_sat = (tex_h_q == '0) ? 9'd1 : ((tex_h_q > TexHCap) ? TexHCap : tex_h_q);
    sw_sat = (src_w_q == '0) ? 9'd1 : ((src_w_q > TexWCap) ? TexWCap : src_w_q);
    sh_sat = (src_h_q == '0) ? 9'd1 : ((src_h_q > TexHCap) ? TexHCap : src_h_q);
    dw_sat = (dst_w_q == '0) ? 11'd1 : ((dst_w_q > DstWCap) ? DstWCap : dst_w_q);
    dh_sat = (dst_h_q == '0) ? 11'd1 : ((dst_h_q > DstHCap) ? DstHCap : dst_h_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= 9'd256;
      tex_h_q <= 9'd256;
      src_x_q <= 8'd0;
      src_y_q <= 8'd0;
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 11'd256;
      dst_h_q <= 11'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nnsb_pkg::RegTexWidth:  tex_w_q <= cfg_data_i[8:0];
        nnsb_pkg::RegTexHeight: tex_h_q <= cfg_data_i[8:0];
        nnsb_pkg::RegSrcX:      src_x_q <= cfg_data_i[7:0];
        nnsb_pkg::RegSrcY:      src_y_q <= cfg_data_i[7:0];
        nnsb_pkg::RegSrcWidth:  src_w_q <= cfg_data_i[8:0];
        nnsb_pkg::RegSrcHeight: src_h_q <= cfg_data_i[8:0];
        nnsb_pkg::RegDstWidth:  dst_w_q <= cfg_data_i;
        nnsb_pkg::RegDstHeight: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (emit) begin
      if (ColXW'(col_q) >= ColXW'(dw_sat) - ColXW'(1)) begin
        col_d = '0;
        if (RowXW'(row_q) >= RowXW'(dh_sat) - RowXW'(1)) begin
          row_d = '0;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      state_q <= nnsb_pkg::StIdle;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      col_out_q <= col_q;
      row_out_q <= row_q;
      last_q    <= (ColXW'(col_q) == ColXW'(dw_sat) - ColXW'(1)) &&
                   (RowXW'(row_q) == RowXW'(dh_sat) - RowXW'(1));
    end
  end

  nnsb_div #(
    .NUM_W(NumXW),
    .DEN_W(11)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(emit),
    .num_i  (NumXW'(col_q) * NumXW'(sw_sat)),
    .den_i  (dw_sat),
    .busy_o (div_x_busy),
    .quot_o (quot_x)
  );

  nnsb_div #(
    .NUM_W(NumYW),
    .DEN_W(11)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(emit),
    .num_i  (NumYW'(row_q) * NumYW'(sh_sat)),
    .den_i  (dh_sat),
    .busy_o (div_y_busy),
    .quot_o (quot_y)
  );

  always_comb begin
    sum_x  = SumXW'(src_x_q) + SumXW'(quot_x);
    sum_y  = SumYW'(src_y_q) + SumYW'(quot_y);
    tx_d   = (sum_x >= SumXW'(tw_sat)) ? (tw_sat - 9'd1) : 9'(sum_x);
    ty_d   = (sum_y >= SumYW'(th_sat)) ? (th_sat - 9'd1) : 9'(sum_y);
    addr_d = nnsb_pkg::StoreAddrW'(ty_q * tw_sat + 18'(tx_q));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == nnsb_pkg::StClamp) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
    end
    if (state_q == nnsb_pkg::StAddr) begin
      addr_q <= addr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      nnsb_pkg::StIdle:   if (emit) state_d = nnsb_pkg::StDivide;
      nnsb_pkg::StDivide: if (!div_x_busy && !div_y_busy) state_d = nnsb_pkg::StClamp;
      nnsb_pkg::StClamp:  state_d = nnsb_pkg::StAddr;
      nnsb_pkg::StAddr:   state_d = nnsb_pkg::StRead;
      nnsb_pkg::StRead:   state_d = nnsb_pkg::StOut;
      nnsb_pkg::StOut:    state_d = nnsb_pkg::StIdle;
      default:            state_d = nnsb_pkg::StIdle;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    out_valid_o = 1'b0;
    ram_addr    = addr_q;
    case (state_q)
      nnsb_pkg::StIdle: begin
        busy     = 1'b0;
        ram_addr = in_i.texel_index;
      end
      nnsb_pkg::StOut: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  nnsb_ram #(
    .WIDTH(nnsb_pkg::TexelW),
    .DEPTH(nnsb_pkg::StoreDepth)
  ) u_texel_store (
    .clk_i  (clk_i),
    .we_i   (texel_write),
    .addr_i (ram_addr),
    .wdata_i(in_i.texel_value[23:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    out_o.red        = ram_rdata[23:16];
    out_o.green      = ram_rdata[15:8];
    out_o.blue       = ram_rdata[7:0];
    out_o.out_column = 10'(col_out_q);
    out_o.out_row    = 10'(row_out_q);
    out_o.frame_last = last_q;
  end

endmodule
